/* rtl/assert_macros.svh */
// Assertion macros for the complex impedance combiner.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define CIC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* rtl/cic_pkg.sv */
// Shared types and fixed widths of the complex impedance combiner.
// No dependencies.
`default_nettype none

package cic_pkg;

  localparam int W      = 32;
  localparam int QDEPTH = 4;
  localparam int QA_W   = 2;

  localparam logic [1:0] ACT_SUM = 2'd0;
  localparam logic [1:0] ACT_PDS = 2'd1;
  localparam logic [1:0] ACT_RCP = 2'd2;

  typedef enum logic [3:0] {
    KIND_SUM = 4'b0001,
    KIND_PDS = 4'b0010,
    KIND_RCP = 4'b0100,
    KIND_NIL = 4'b1000
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic signed [W-1:0]  ar;
    logic signed [W-1:0]  ai;
    logic signed [W-1:0]  br;
    logic signed [W-1:0]  bi;
  } item_t;

  typedef struct packed {
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         inf;
    logic         sat;
  } result_t;

endpackage

`default_nettype wire

/* rtl/cic_front.sv */
// Front stage: accepts operands, sign-extends them to the word width and
// decodes the action. Depends on cic_pkg.
`default_nettype none

module cic_front #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic signed [cic_pkg::W-1:0] a_re_i,
  input  wire logic signed [cic_pkg::W-1:0] a_im_i,
  input  wire logic signed [cic_pkg::W-1:0] b_re_i,
  input  wire logic signed [cic_pkg::W-1:0] b_im_i,
  output cic_pkg::item_t                  item_o,
  output logic                            vld_o,
  input  wire logic                       rdy_i
);

  localparam int OP_W = (DATA_WIDTH < cic_pkg::W) ? DATA_WIDTH : cic_pkg::W;
  localparam int SH   = cic_pkg::W - OP_W;

  logic            vld_q, vld_d;
  cic_pkg::item_t  item_q, item_d;
  logic            take;

  function automatic logic signed [cic_pkg::W-1:0] sext(
    input logic signed [cic_pkg::W-1:0] x);
    logic signed [cic_pkg::W-1:0] t;
    t = x <<< SH;
    return t >>> SH;
  endfunction

  assign full_o = vld_q && !rdy_i;
  assign take   = push_i && !full_o;
  assign vld_o  = vld_q;
  assign item_o = item_q;

  always_comb begin
    item_d.ar = sext(a_re_i);
    item_d.ai = sext(a_im_i);
    item_d.br = sext(b_re_i);
    item_d.bi = sext(b_im_i);
    case (action_i)
      cic_pkg::ACT_SUM: item_d.kind = cic_pkg::KIND_SUM;
      cic_pkg::ACT_PDS: item_d.kind = cic_pkg::KIND_PDS;
      cic_pkg::ACT_RCP: item_d.kind = cic_pkg::KIND_RCP;
      default:          item_d.kind = cic_pkg::KIND_NIL;
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/cic_queue.sv */
// Short queue between front and back stages.
// Depends on cic_pkg.
`default_nettype none

module cic_queue (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  cic_pkg::item_t item_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output cic_pkg::item_t item_o,
  output logic        empty_o
);

  cic_pkg::item_t               mem_q [cic_pkg::QDEPTH];
  logic [cic_pkg::QA_W-1:0]     wp_q, rp_q;
  logic [cic_pkg::QA_W:0]       cnt_q;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == (cic_pkg::QA_W+1)'(cic_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/cic_back.sv */
// Back pipeline: complex products, denominator, restoring divider with one
// quotient bit per stage, saturation and the result register. Depends on cic_pkg.
`default_nettype none

module cic_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  cic_pkg::item_t item_i,
  input  wire logic      item_vld_i,
  output logic           item_pop_o,
  output cic_pkg::result_t res_o,
  output logic           res_vld_o,
  input  wire logic      res_pop_i
);

  localparam int W    = cic_pkg::W;
  localparam int OP_W = (DATA_WIDTH < W) ? DATA_WIDTH : W;
  localparam int S_W  = W + 1;
  localparam int M_W  = 2 * W;
  localparam int PP_W = M_W + 1;
  localparam int PM_W = M_W;
  localparam int H_W  = W;
  localparam int Q_W  = W + 1;
  localparam int N_W  = PM_W + S_W + 2;
  localparam int NM_W = N_W - 1;
  localparam int D_W  = 2 * S_W + 1;
  localparam int R_W  = D_W + Q_W;
  localparam int V_W  = Q_W + 2;
  localparam int NPRE = 7;

  localparam logic signed [V_W-1:0] VMAX = V_W'((64'd1 << (OP_W-1)) - 64'd1);
  localparam logic signed [V_W-1:0] VMIN = ~VMAX;

  typedef struct packed {
    cic_pkg::kind_e          kind;
    logic signed [S_W-1:0]   sr;
    logic signed [S_W-1:0]   si;
    logic                    dz;
  } car_t;

  typedef struct packed {
    logic ovr;
    logic ovi;
    logic ngr;
    logic ngi;
  } dfl_t;

  logic en;
  logic [NPRE-1:0] pv_q;
  logic [Q_W:0]    dv_q;
  logic            res_vld_q;
  cic_pkg::result_t res_q, res_d;

  // stage 1
  car_t                    c1_q, c1_d;
  logic signed [M_W-1:0]   m1_q, m2_q, m3_q, m4_q;
  // stage 2
  car_t                    c2_q;
  logic signed [PP_W-1:0]  pr2_q, pi2_q, pr2_d, pi2_d;
  logic signed [2*S_W-1:0] sqr2_q, sqi2_q;
  // stage 3
  car_t                    c3_q;
  logic [D_W-1:0]          den3_q;
  logic [PM_W-1:0]         xm3_q [2];
  logic [S_W-1:0]          sm3_q [2];
  logic                    xs3_q [2];
  logic                    ss3_q [2];
  logic [PM_W-1:0]         xm3_d [2];
  logic [S_W-1:0]          sm3_d [2];
  logic signed [PP_W-1:0]  pabs  [2];
  logic signed [S_W-1:0]   sabs  [2];
  // stage 4
  car_t                    c4_q;
  logic [D_W-1:0]          den4_q;
  logic [PP_W-1:0]         pl4_q [4];
  logic [PP_W-1:0]         ph4_q [4];
  logic                    ps4_q [4];
  // stage 5
  car_t                    c5_q;
  logic [D_W-1:0]          den5_q;
  logic signed [N_W-1:0]   pd5_q [4];
  // stage 6
  car_t                    c6_q;
  logic [D_W-1:0]          den6_q;
  logic signed [N_W-1:0]   nre6_q, nim6_q;
  // stage 7
  car_t                    c7_q;
  logic [D_W-1:0]          den7_q;
  logic [NM_W-1:0]         mre7_q, mim7_q;
  logic                    ngr7_q, ngi7_q;
  logic signed [N_W-1:0]   are7, aim7;
  // divider stages
  car_t                    dc_q  [Q_W+1];
  dfl_t                    df_q  [Q_W+1];
  logic [D_W-1:0]          dd_q  [Q_W+1];
  logic [R_W-1:0]          drr_q [Q_W+1];
  logic [R_W-1:0]          dri_q [Q_W+1];
  logic [Q_W-1:0]          dqr_q [Q_W+1];
  logic [Q_W-1:0]          dqi_q [Q_W+1];

  assign en         = !res_vld_q || res_pop_i;
  assign item_pop_o = en && item_vld_i;
  assign res_o      = res_q;
  assign res_vld_o  = res_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= '0;
      dv_q      <= '0;
      res_vld_q <= 1'b0;
    end else if (en) begin
      pv_q      <= {pv_q[NPRE-2:0], item_vld_i};
      dv_q      <= {dv_q[Q_W-1:0], pv_q[NPRE-1]};
      res_vld_q <= dv_q[Q_W];
    end
  end

  // stage 1: operand sum and cross products
  always_comb begin
    c1_d.kind = item_i.kind;
    c1_d.dz   = 1'b0;
    if (item_i.kind == cic_pkg::KIND_RCP) begin
      c1_d.sr = S_W'(item_i.ar);
      c1_d.si = S_W'(item_i.ai);
    end else begin
      c1_d.sr = S_W'(item_i.ar) + S_W'(item_i.br);
      c1_d.si = S_W'(item_i.ai) + S_W'(item_i.bi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= c1_d;
      m1_q <= item_i.ar * item_i.br;
      m2_q <= item_i.ai * item_i.bi;
      m3_q <= item_i.ar * item_i.bi;
      m4_q <= item_i.br * item_i.ai;
    end
  end

  // stage 2: product of operands, squares of the sum
  always_comb begin
    if (c1_q.kind == cic_pkg::KIND_RCP) begin
      pr2_d = PP_W'(1) <<< (2 * FRAC_BITS);
      pi2_d = '0;
    end else begin
      pr2_d = PP_W'(m1_q) - PP_W'(m2_q);
      pi2_d = PP_W'(m3_q) + PP_W'(m4_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q   <= c1_q;
      pr2_q  <= pr2_d;
      pi2_q  <= pi2_d;
      sqr2_q <= c1_q.sr * c1_q.sr;
      sqi2_q <= c1_q.si * c1_q.si;
    end
  end

  // stage 3: denominator and sign-magnitude split
  always_comb begin
    pabs[0]  = pr2_q[PP_W-1] ? -pr2_q : pr2_q;
    pabs[1]  = pi2_q[PP_W-1] ? -pi2_q : pi2_q;
    sabs[0]  = c2_q.sr[S_W-1] ? -c2_q.sr : c2_q.sr;
    sabs[1]  = c2_q.si[S_W-1] ? -c2_q.si : c2_q.si;
    xm3_d[0] = pabs[0][PM_W-1:0];
    xm3_d[1] = pabs[1][PM_W-1:0];
    sm3_d[0] = sabs[0];
    sm3_d[1] = sabs[1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q     <= c2_q;
      den3_q   <= D_W'($unsigned(sqr2_q)) + D_W'($unsigned(sqi2_q));
      xm3_q[0] <= xm3_d[0];
      xm3_q[1] <= xm3_d[1];
      sm3_q[0] <= sm3_d[0];
      sm3_q[1] <= sm3_d[1];
      xs3_q[0] <= pr2_q[PP_W-1];
      xs3_q[1] <= pi2_q[PP_W-1];
      ss3_q[0] <= c2_q.sr[S_W-1];
      ss3_q[1] <= c2_q.si[S_W-1];
    end
  end

  // stage 4: partial products of P with conj(S)
  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q    <= '{kind: c3_q.kind, sr: c3_q.sr, si: c3_q.si, dz: (den3_q == '0)};
      den4_q  <= den3_q;
      for (int k = 0; k < 4; k++) begin
        pl4_q[k] <= PP_W'(xm3_q[k == 1 || k == 2][H_W-1:0]) *
                    PP_W'(sm3_q[k == 1 || k == 3]);
        ph4_q[k] <= PP_W'(xm3_q[k == 1 || k == 2][PM_W-1:H_W]) *
                    PP_W'(sm3_q[k == 1 || k == 3]);
        ps4_q[k] <= xs3_q[k == 1 || k == 2] ^
                    ss3_q[k == 1 || k == 3];
      end
    end
  end

  // stage 5: signed products
  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q   <= c4_q;
      den5_q <= den4_q;
      for (int k = 0; k < 4; k++) begin
        pd5_q[k] <= ps4_q[k] ? -(N_W'(pl4_q[k]) + (N_W'(ph4_q[k]) << H_W))
                             :  (N_W'(pl4_q[k]) + (N_W'(ph4_q[k]) << H_W));
      end
    end
  end

  // stage 6: numerators
  always_ff @(posedge clk_i) begin
    if (en) begin
      c6_q   <= c5_q;
      den6_q <= den5_q;
      nre6_q <= pd5_q[0] + pd5_q[1];
      nim6_q <= pd5_q[2] - pd5_q[3];
    end
  end

  // stage 7: numerator magnitudes
  assign are7 = nre6_q[N_W-1] ? -nre6_q : nre6_q;
  assign aim7 = nim6_q[N_W-1] ? -nim6_q : nim6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c7_q   <= c6_q;
      den7_q <= den6_q;
      mre7_q <= are7[NM_W-1:0];
      mim7_q <= aim7[NM_W-1:0];
      ngr7_q <= nre6_q[N_W-1];
      ngi7_q <= nim6_q[N_W-1];
    end
  end

  // divider entry: overflow check against the full quotient width
  always_ff @(posedge clk_i) begin
    if (en) begin
      dc_q[0]     <= c7_q;
      dd_q[0]     <= den7_q;
      drr_q[0]    <= R_W'(mre7_q);
      dri_q[0]    <= R_W'(mim7_q);
      dqr_q[0]    <= '0;
      dqi_q[0]    <= '0;
      df_q[0].ovr <= R_W'(mre7_q) >= (R_W'(den7_q) << Q_W);
      df_q[0].ovi <= R_W'(mim7_q) >= (R_W'(den7_q) << Q_W);
      df_q[0].ngr <= ngr7_q;
      df_q[0].ngi <= ngi7_q;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int B = Q_W - 1 - j;
    logic [R_W:0] sub_r, sub_i;

    assign sub_r = {1'b0, drr_q[j]} - {1'b0, R_W'(dd_q[j]) << B};
    assign sub_i = {1'b0, dri_q[j]} - {1'b0, R_W'(dd_q[j]) << B};

    always_ff @(posedge clk_i) begin
      if (en) begin
        dc_q[j+1]  <= dc_q[j];
        df_q[j+1]  <= df_q[j];
        dd_q[j+1]  <= dd_q[j];
        drr_q[j+1] <= sub_r[R_W] ? drr_q[j] : sub_r[R_W-1:0];
        dri_q[j+1] <= sub_i[R_W] ? dri_q[j] : sub_i[R_W-1:0];
        dqr_q[j+1] <= {dqr_q[j][Q_W-2:0], !sub_r[R_W]};
        dqi_q[j+1] <= {dqi_q[j][Q_W-2:0], !sub_i[R_W]};
      end
    end
  end

  // result: {saturated, word}
  function automatic logic [W:0] clamp(input logic signed [V_W-1:0] v);
    if (v > VMAX) begin
      return {1'b1, VMAX[W-1:0]};
    end else if (v < VMIN) begin
      return {1'b1, VMIN[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] quot(input logic [Q_W-1:0] q, input logic ov,
                                      input logic ng);
    logic signed [V_W-1:0] v;
    v = $signed({2'b00, q});
    if (ov) begin
      return {1'b1, ng ? VMIN[W-1:0] : VMAX[W-1:0]};
    end
    return clamp(ng ? -v : v);
  endfunction

  always_comb begin
    logic [W:0] cr, ci;
    cr = '0;
    ci = '0;
    res_d.inf = 1'b0;
    case (dc_q[Q_W].kind)
      cic_pkg::KIND_SUM: begin
        cr = clamp(V_W'(dc_q[Q_W].sr));
        ci = clamp(V_W'(dc_q[Q_W].si));
      end
      cic_pkg::KIND_PDS, cic_pkg::KIND_RCP: begin
        if (dc_q[Q_W].dz) begin
          res_d.inf = 1'b1;
          cr = {1'b0, VMAX[W-1:0]};
        end else begin
          cr = quot(dqr_q[Q_W], df_q[Q_W].ovr, df_q[Q_W].ngr);
          ci = quot(dqi_q[Q_W], df_q[Q_W].ovi, df_q[Q_W].ngi);
        end
      end
      default: begin
        cr = '0;
        ci = '0;
      end
    endcase
    res_d.re  = cr[W-1:0];
    res_d.im  = ci[W-1:0];
    res_d.sat = cr[W] | ci[W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/complex_impedance_combiner.sv */
// Complex impedance combiner: sum, product over sum, or reciprocal of signed
// fixed-point complex operands. One item per clock cycle enters while full is low.
// The result passes through the input register, the queue, seven product stages,
// the divider entry, the 33-stage restoring divider that produces one quotient
// bit per stage for both parts in parallel, and the result register. A four-entry
// queue separates the input stage from the pipeline, and the pipeline holds while
// a finished result waits to be popped.
// Depends on cic_pkg, cic_front, cic_queue, cic_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module complex_impedance_combiner #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 action_i,
  input  wire logic signed [cic_pkg::W-1:0] a_re_i,
  input  wire logic signed [cic_pkg::W-1:0] a_im_i,
  input  wire logic signed [cic_pkg::W-1:0] b_re_i,
  input  wire logic signed [cic_pkg::W-1:0] b_im_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic signed [cic_pkg::W-1:0]    out_re_o,
  output logic signed [cic_pkg::W-1:0]    out_im_o,
  output logic                            infinite_o,
  output logic                            saturated_o
);

  localparam int W    = cic_pkg::W;
  localparam int OP_W = (DATA_WIDTH < W) ? DATA_WIDTH : W;
  localparam logic [W-1:0] WMAX = W'((64'd1 << (OP_W-1)) - 64'd1);
  localparam logic [W-1:0] WMIN = ~WMAX;

  cic_pkg::item_t   f_item, q_item;
  cic_pkg::result_t res;
  logic             f_vld, q_full, q_empty, q_pop, res_vld;

  cic_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .action_i(action_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .item_o  (f_item),
    .vld_o   (f_vld),
    .rdy_i   (!q_full)
  );

  cic_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_vld),
    .item_i (f_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .item_o (q_item),
    .empty_o(q_empty)
  );

  cic_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (q_item),
    .item_vld_i(!q_empty),
    .item_pop_o(q_pop),
    .res_o     (res),
    .res_vld_o (res_vld),
    .res_pop_i (pop)
  );

  assign empty       = !res_vld;
  assign out_re_o    = res.re;
  assign out_im_o    = res.im;
  assign infinite_o  = res.inf;
  assign saturated_o = res.sat;

  `CIC_ASSERT_IMP(a_inf_form, !empty && infinite_o, (out_re_o == WMAX) && (out_im_o == '0), "infinite result not in canonical form")
  `CIC_ASSERT_NEVER(a_inf_sat, !empty && infinite_o && saturated_o, "infinite and saturated together")
  `CIC_ASSERT_IMP(a_sat_edge, !empty && saturated_o, (out_re_o == WMAX) || (out_re_o == WMIN) || (out_im_o == WMAX) || (out_im_o == WMIN), "saturated result off range edge")

endmodule

`default_nettype wire
